/* hw/rtl/hse_pkg.sv */
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types, constants and the microcode program of the heap sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

   localparam int HSE_DEPTH       = 64;
   localparam int HSE_VALUE_WIDTH = 32;
   localparam int DATA_W          = 32;
   localparam int STEP_W          = 5;

   typedef struct packed {
      logic [DATA_W-1:0] data_value;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] sorted_value;
      logic              end_of_run;
      logic              overflowed;
   } rsp_type;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_BINIT,
      ACT_BNODE,
      ACT_RD_ROOT,
      ACT_RD_TAIL,
      ACT_WR_ROOT,
      ACT_WR_TAIL,
      ACT_EINIT,
      ACT_RD_EMIT,
      ACT_EMIT,
      ACT_CLEAR,
      ACT_RD_NODE,
      ACT_RD_LEFT,
      ACT_RD_RIGHT,
      ACT_CMP_RIGHT,
      ACT_WR_NODE,
      ACT_WR_BEST
   } act_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_NOT_START,
      C_K_ZERO,
      C_N_LE1,
      C_NO_LEFT,
      C_BEST_IS_NODE,
      C_OUT_BUSY,
      C_EMIT_MORE
   } cond_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_GOTO,
      BR_CALL,
      BR_RET
   } br_type;

   typedef struct packed {
      act_type           act;
      cond_type          cond;
      br_type            br;
      logic [STEP_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic start;
      logic k_zero;
      logic n_le1;
      logic no_left;
      logic best_is_node;
      logic out_busy;
      logic emit_more;
   } stat_type;

   // program step addresses
   localparam logic [STEP_W-1:0] ST_LOAD  = 5'd0;
   localparam logic [STEP_W-1:0] ST_BINIT = 5'd1;
   localparam logic [STEP_W-1:0] ST_BLOOP = 5'd2;
   localparam logic [STEP_W-1:0] ST_BNODE = 5'd3;
   localparam logic [STEP_W-1:0] ST_BBACK = 5'd4;
   localparam logic [STEP_W-1:0] ST_T0    = 5'd5;
   localparam logic [STEP_W-1:0] ST_T1    = 5'd6;
   localparam logic [STEP_W-1:0] ST_T2    = 5'd7;
   localparam logic [STEP_W-1:0] ST_T3    = 5'd8;
   localparam logic [STEP_W-1:0] ST_T4    = 5'd9;
   localparam logic [STEP_W-1:0] ST_EINIT = 5'd10;
   localparam logic [STEP_W-1:0] ST_E1    = 5'd11;
   localparam logic [STEP_W-1:0] ST_E2    = 5'd12;
   localparam logic [STEP_W-1:0] ST_E3    = 5'd13;
   localparam logic [STEP_W-1:0] ST_EDONE = 5'd14;
   localparam logic [STEP_W-1:0] ST_S0    = 5'd15;
   localparam logic [STEP_W-1:0] ST_S1    = 5'd16;
   localparam logic [STEP_W-1:0] ST_S2    = 5'd17;
   localparam logic [STEP_W-1:0] ST_S3    = 5'd18;
   localparam logic [STEP_W-1:0] ST_S4    = 5'd19;
   localparam logic [STEP_W-1:0] ST_S5    = 5'd20;

   function automatic uword_type uw(input act_type a, input cond_type c, input br_type b,
                                    input logic [STEP_W-1:0] t);
      uword_type w;
      w.act    = a;
      w.cond   = c;
      w.br     = b;
      w.target = t;
      return w;
   endfunction

   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      unique case (step)
         ST_LOAD:  w = uw(ACT_LOAD,      C_NOT_START,    BR_GOTO, ST_LOAD);
         ST_BINIT: w = uw(ACT_BINIT,     C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_BLOOP: w = uw(ACT_NONE,      C_K_ZERO,       BR_GOTO, ST_T0);
         ST_BNODE: w = uw(ACT_BNODE,     C_ALWAYS,       BR_CALL, ST_S0);
         ST_BBACK: w = uw(ACT_NONE,      C_ALWAYS,       BR_GOTO, ST_BLOOP);
         ST_T0:    w = uw(ACT_RD_ROOT,   C_N_LE1,        BR_GOTO, ST_EINIT);
         ST_T1:    w = uw(ACT_RD_TAIL,   C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_T2:    w = uw(ACT_WR_ROOT,   C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_T3:    w = uw(ACT_WR_TAIL,   C_ALWAYS,       BR_CALL, ST_S0);
         ST_T4:    w = uw(ACT_NONE,      C_ALWAYS,       BR_GOTO, ST_T0);
         ST_EINIT: w = uw(ACT_EINIT,     C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_E1:    w = uw(ACT_RD_EMIT,   C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_E2:    w = uw(ACT_EMIT,      C_OUT_BUSY,     BR_GOTO, ST_E2);
         ST_E3:    w = uw(ACT_NONE,      C_EMIT_MORE,    BR_GOTO, ST_E1);
         ST_EDONE: w = uw(ACT_CLEAR,     C_ALWAYS,       BR_GOTO, ST_LOAD);
         ST_S0:    w = uw(ACT_RD_NODE,   C_NO_LEFT,      BR_RET,  ST_LOAD);
         ST_S1:    w = uw(ACT_RD_LEFT,   C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_S2:    w = uw(ACT_RD_RIGHT,  C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_S3:    w = uw(ACT_CMP_RIGHT, C_ALWAYS,       BR_NEXT, ST_LOAD);
         ST_S4:    w = uw(ACT_WR_NODE,   C_BEST_IS_NODE, BR_RET,  ST_LOAD);
         ST_S5:    w = uw(ACT_WR_BEST,   C_ALWAYS,       BR_GOTO, ST_S0);
         default:  w = uw(ACT_NONE,      C_ALWAYS,       BR_GOTO, ST_LOAD);
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/heap_sort_engine.sv */
// ----------------------------------------------------------------------------
// heap_sort_engine
// Heapsort of one set of values held in a RAM, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Load: one beat per cycle; the beat marked last starts the sort.
// Sort: each sift level makes three reads and two writes (one RAM read port).
// Emit: each result beat is read from the store and then sent, waiting while the
//   output is stalled; after the last beat the next set is taken.
// Reset clears the sequencer, item count, overflow flag, order bit and output
//   valid; the store needs no clearing since only written entries are used.
// ----------------------------------------------------------------------------
module heap_sort_engine
   import hse_pkg::*;
#(
   parameter int DEPTH       = HSE_DEPTH,
   parameter int VALUE_WIDTH = HSE_VALUE_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   localparam int SW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = CW + 1;

   uword_type ctrl;
   stat_type  stat;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic          desc_ff;
   logic [CW-1:0] size_ff, size_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] e_ff, e_in;
   logic [AW-1:0] node_ff, node_in;
   logic [AW-1:0] best_ff, best_in;
   logic [SW-1:0] nval_ff, nval_in;
   logic [SW-1:0] bval_ff, bval_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] rd_data;

   logic [IW-1:0] left_idx;
   logic [IW-1:0] right_idx;
   logic [CW-1:0] tail;
   logic [CW-1:0] k_dec;
   logic [CW-1:0] e_inc;
   logic          req_beat;
   logic          out_busy;

   function automatic logic above(input logic desc, input logic [SW-1:0] a,
                                  input logic [SW-1:0] b);
      return desc ? (a < b) : (a > b);
   endfunction

   hse_useq u_useq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   hse_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (ctrl.act == ACT_LOAD);
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign left_idx  = (IW'(node_ff) << 1) + IW'(1);
   assign right_idx = left_idx + IW'(1);
   assign tail      = size_ff - CW'(1);
   assign k_dec     = k_ff - CW'(1);
   assign e_inc     = e_ff + CW'(1);
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      stat.start        = req_beat && req_payload.is_last;
      stat.k_zero       = (k_ff == '0);
      stat.n_le1        = (size_ff <= CW'(1));
      stat.no_left      = (left_idx >= IW'(size_ff));
      stat.best_is_node = (best_ff == node_ff);
      stat.out_busy     = out_busy;
      stat.emit_more    = (e_ff < cnt_ff);
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      size_in      = size_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      node_in      = node_ff;
      best_in      = best_ff;
      nval_in      = nval_ff;
      bval_in      = bval_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = '0;
      unique case (ctrl.act)
         ACT_NONE: begin
         end
         ACT_LOAD: begin
            if (req_beat) begin
               if (cnt_ff < CW'(DEPTH)) begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[AW-1:0];
                  wr_data = req_payload.data_value[SW-1:0];
                  cnt_in  = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ACT_BINIT: begin
            size_in = cnt_ff;
            k_in    = (cnt_ff >> 1) + CW'(1);
         end
         ACT_BNODE: begin
            k_in    = k_dec;
            node_in = k_dec[AW-1:0];
         end
         ACT_RD_ROOT: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ACT_RD_TAIL: begin
            nval_in = rd_data;
            rd_en   = 1'b1;
            rd_addr = tail[AW-1:0];
         end
         ACT_WR_ROOT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = rd_data;
         end
         ACT_WR_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = tail[AW-1:0];
            wr_data = nval_ff;
            size_in = tail;
            node_in = '0;
         end
         ACT_EINIT: begin
            e_in = '0;
         end
         ACT_RD_EMIT: begin
            rd_en   = 1'b1;
            rd_addr = e_ff[AW-1:0];
         end
         ACT_EMIT: begin
            if (!out_busy) begin
               rsp_in.sorted_value = DATA_W'(rd_data);
               rsp_in.end_of_run   = (e_inc == cnt_ff);
               rsp_in.overflowed   = ovf_ff;
               rsp_valid_in        = 1'b1;
               e_in                = e_inc;
            end
         end
         ACT_CLEAR: begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end
         ACT_RD_NODE: begin
            rd_en   = 1'b1;
            rd_addr = node_ff;
         end
         ACT_RD_LEFT: begin
            nval_in = rd_data;
            bval_in = rd_data;
            best_in = node_ff;
            rd_en   = 1'b1;
            rd_addr = left_idx[AW-1:0];
         end
         ACT_RD_RIGHT: begin
            if (above(desc_ff, rd_data, bval_ff)) begin
               best_in = left_idx[AW-1:0];
               bval_in = rd_data;
            end
            rd_en   = 1'b1;
            rd_addr = right_idx[AW-1:0];
         end
         ACT_CMP_RIGHT: begin
            if ((right_idx < IW'(size_ff)) && above(desc_ff, rd_data, bval_ff)) begin
               best_in = right_idx[AW-1:0];
               bval_in = rd_data;
            end
         end
         ACT_WR_NODE: begin
            wr_en   = 1'b1;
            wr_addr = node_ff;
            wr_data = bval_ff;
         end
         ACT_WR_BEST: begin
            wr_en   = 1'b1;
            wr_addr = best_ff;
            wr_data = nval_ff;
            node_in = best_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            desc_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      k_ff    <= k_in;
      e_ff    <= e_in;
      node_ff <= node_in;
      best_ff <= best_in;
      nval_ff <= nval_in;
      bval_ff <= bval_in;
      rsp_ff  <= rsp_in;
   end

endmodule

/* hw/rtl/hse_ram.sv */
// ----------------------------------------------------------------------------
// hse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/hse_useq.sv */
// ----------------------------------------------------------------------------
// hse_useq
// Microcode sequencer: step counter, program ROM, conditional jumps and a
// one-level call/return register.
// ----------------------------------------------------------------------------
module hse_useq
   import hse_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  stat_type  stat,
   output uword_type ctrl
);

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   logic [STEP_W-1:0] ret_ff;
   logic [STEP_W-1:0] ret_in;
   logic [STEP_W-1:0] upc_next;
   logic              take;

   assign ctrl     = ucode_rom(upc_ff);
   assign upc_next = upc_ff + STEP_W'(1);

   always_comb begin
      unique case (ctrl.cond)
         C_ALWAYS:       take = 1'b1;
         C_NOT_START:    take = !stat.start;
         C_K_ZERO:       take = stat.k_zero;
         C_N_LE1:        take = stat.n_le1;
         C_NO_LEFT:      take = stat.no_left;
         C_BEST_IS_NODE: take = stat.best_is_node;
         C_OUT_BUSY:     take = stat.out_busy;
         C_EMIT_MORE:    take = stat.emit_more;
         default:        take = 1'b1;
      endcase
   end

   always_comb begin
      upc_in = upc_next;
      ret_in = ret_ff;
      unique case (ctrl.br)
         BR_NEXT: begin
            upc_in = upc_next;
         end
         BR_GOTO: begin
            if (take) begin
               upc_in = ctrl.target;
            end
         end
         BR_CALL: begin
            if (take) begin
               upc_in = ctrl.target;
               ret_in = upc_next;
            end
         end
         BR_RET: begin
            if (take) begin
               upc_in = ret_ff;
            end
         end
         default: begin
            upc_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_LOAD;
         ret_ff <= ST_LOAD;
      end else begin
         upc_ff <= upc_in;
         ret_ff <= ret_in;
      end
   end

endmodule
